@@ hw/rtl/rgq_pkg.sv @@
// Shared types and constants for the ratio graph query engine.
`default_nettype none
package rgq_pkg;

    localparam int unsigned NODES    = 32;
    localparam int unsigned NODE_W   = 5;
    localparam logic [31:0] ONE_Q16  = 32'h0001_0000;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_UNKNOWN = 3'd2,
        ST_UNREACH = 3'd3,
        ST_WALK    = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]        operation;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
        logic [31:0]       weight;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] ratio;
    } t_out_item;

    typedef struct packed {
        logic [NODE_W-1:0] from_node;
        logic [NODE_W-1:0] to_node;
        logic [31:0]       wt;
    } t_edge;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_QSCAN,
        S_QPICK,
        S_ERD,
        S_ECHK,
        S_EUPD,
        S_QEND,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

@@ hw/rtl/rgq_recip.sv @@
// Bit-serial reciprocal unit: floor(2^32 / d), saturated to 32 bits.
`default_nettype none
module rgq_recip
    import rgq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quot
);

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [32:0] r_q;
    logic [31:0] r_d;
    logic [32:0] n_shift;
    logic        n_ge;

    // remainder stays below the divisor, so 32 bits plus the shifted-in bit suffice
    assign n_shift = {r_rem, r_q[32]};
    assign n_ge    = n_shift >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == 6'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd33;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_q   <= 33'h1_0000_0000;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? 32'(n_shift - {1'b0, r_d}) : n_shift[31:0];
            r_q   <= {r_q[31:0], n_ge};
        end
    end

    // divisor zero or one leaves the top quotient bit set
    assign o_done = r_done;
    assign o_quot = r_q[32] ? 32'hFFFF_FFFF : r_q[31:0];

endmodule
`default_nettype wire

@@ hw/rtl/rgq_mulsat.sv @@
// Registered Q16.16 multiplier with saturation after the product register.
`default_nettype none
module rgq_mulsat
    import rgq_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic [31:0]      o_p
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_p = (|r_prod[63:48]) ? 32'hFFFF_FFFF : r_prod[47:16];

endmodule
`default_nettype wire

@@ hw/rtl/ratio_graph_query_engine_core.sv @@
// Ratio graph query engine: edge and product memories with the walk sequencer.
//
// Input channel i_in_valid / o_in_stall carries one command item: clear, add
// an equation a/b = weight, or query the product ratio from a to b. Output
// channel o_out_valid / i_out_stall returns one result item per command.
// One item is worked on at a time; a new one is taken while the previous
// result still waits in the output register.
// Steps: clear, no-op, a rejected add and a query on an unknown node go
// straight to the finish state; an add first waits for the reciprocal
// divider, which works one bit per cycle. Each query extraction takes a
// pending-node scan of the product memory, a pick, and an edge pass that
// reads every stored edge, updates on each edge leaving the extracted node
// and then closes; after at most WALK_LIMIT extractions a last scan and
// the finish follow.
// Reset empties the edge table and node marks; no clearing pass is needed.
// While the receiver stalls, a finished result holds in the output
// register and the next item's result waits in the sequencer until it
// drains.
`default_nettype none
module ratio_graph_query_engine_core
    import rgq_pkg::*;
#(
    parameter int unsigned MAX_EDGES  = 64,
    parameter int unsigned WALK_LIMIT = 1024
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam int unsigned EW = $clog2(MAX_EDGES);
    localparam int unsigned CW = $clog2(MAX_EDGES + 1);
    localparam int unsigned WW = $clog2(WALK_LIMIT + 1);

    t_edge       edge_mem [MAX_EDGES];
    logic [31:0] best_mem [NODES];

    t_state r_state, n_state;

    logic [CW-1:0]     r_count;
    logic [NODES-1:0]  r_present, r_reached, r_pending;
    logic [NODE_W-1:0] r_a, r_b, r_u, r_v;
    logic [31:0]       r_w, r_bu, r_min;
    logic              r_found;
    logic [NODE_W:0]   r_i;
    logic [CW-1:0]     r_e;
    logic [WW-1:0]     r_walks;
    t_status           r_status;
    logic [31:0]       r_ratio;

    logic              accept;
    logic              out_free;
    t_edge             edge_rd, edge_wd;
    logic              edge_we;
    logic [EW-1:0]     edge_wa, edge_ra;
    logic [31:0]       best_rd, best_wd;
    logic              best_we;
    logic [NODE_W-1:0] best_wa, best_ra;
    logic              div_start, div_done;
    logic [31:0]       div_q;
    logic [31:0]       mul_p;
    logic [NODE_W-1:0] scan_j;
    logic              scan_take;
    logic              upd_take;
    logic [CW:0]       count_need;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !o_out_valid || !i_out_stall;
    assign count_need = {1'b0, r_count} + (CW+1)'(2);

    rgq_recip u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (r_w),
        .o_done    (div_done),
        .o_quot    (div_q)
    );

    rgq_mulsat u_mul (
        .i_clk (i_clk),
        .i_a   (r_bu),
        .i_b   (edge_rd.wt),
        .o_p   (mul_p)
    );

    // memories
    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            edge_mem[edge_wa] <= edge_wd;
        end
        edge_rd <= edge_mem[edge_ra];
    end

    always_ff @(posedge i_clk) begin
        if (best_we) begin
            best_mem[best_wa] <= best_wd;
        end
        best_rd <= best_mem[best_ra];
    end

    // scan compares the data read for the previous index
    assign scan_j    = NODE_W'(r_i - (NODE_W+1)'(1));
    assign scan_take = (r_i != '0) && r_pending[scan_j] && (!r_found || best_rd < r_min);
    assign upd_take  = !r_reached[r_v] || (best_rd > mul_p);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (t_op'(i_in_item.operation))
                        OP_ADD: begin
                            if (count_need <= (CW+1)'(MAX_EDGES)) begin
                                n_state = S_DIV;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        OP_QUERY: begin
                            if (r_present[i_in_item.node_a] && r_present[i_in_item.node_b]) begin
                                n_state = S_QSCAN;
                            end else begin
                                n_state = S_FIN;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_DIV:   if (div_done) n_state = S_FIN;
            S_QSCAN: if (r_i == (NODE_W+1)'(NODES)) n_state = S_QPICK;
            S_QPICK: begin
                if (!r_found) begin
                    n_state = S_QEND;
                end else if (r_walks >= WW'(WALK_LIMIT)) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_ERD;
                end
            end
            S_ERD:   n_state = (r_e == r_count) ? S_QSCAN : S_ECHK;
            S_ECHK:  n_state = (edge_rd.from_node == r_u) ? S_EUPD : S_ERD;
            S_EUPD:  n_state = S_ERD;
            S_QEND:  n_state = S_FIN;
            S_FIN:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory ports and unit controls
    always_comb begin
        edge_we   = 1'b0;
        edge_wa   = r_count[EW-1:0];
        edge_wd   = '{from_node: i_in_item.node_a, to_node: i_in_item.node_b,
                      wt: i_in_item.weight};
        edge_ra   = r_e[EW-1:0];
        best_we   = 1'b0;
        best_wa   = i_in_item.node_a;
        best_wd   = ONE_Q16;
        best_ra   = r_i[NODE_W-1:0];
        div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && t_op'(i_in_item.operation) == OP_ADD &&
                    count_need <= (CW+1)'(MAX_EDGES)) begin
                    edge_we = 1'b1;
                end
                if (accept && t_op'(i_in_item.operation) == OP_QUERY) begin
                    best_we = 1'b1;
                end
            end
            S_DIV: begin
                div_start = !div_done && r_i == '1;
                edge_wa   = EW'(r_count + CW'(1));
                edge_wd   = '{from_node: r_b, to_node: r_a, wt: div_q};
                edge_we   = div_done;
            end
            S_QPICK: best_ra = r_b;
            S_ECHK:  best_ra = edge_rd.to_node;
            S_EUPD: begin
                best_wa = r_v;
                best_wd = mul_p;
                best_we = upd_take;
            end
            default: ;
        endcase
    end

    // control and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_present   <= '0;
            r_reached   <= '0;
            r_pending   <= '0;
            r_i         <= '0;
            r_found     <= 1'b0;
            r_e         <= '0;
            r_walks     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN) begin
                if (out_free) begin
                    o_out_valid <= 1'b1;
                end
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_a      <= i_in_item.node_a;
                        r_b      <= i_in_item.node_b;
                        r_w      <= i_in_item.weight;
                        r_ratio  <= '0;
                        case (t_op'(i_in_item.operation))
                            OP_CLEAR: begin
                                r_count   <= '0;
                                r_present <= '0;
                                r_status  <= ST_OK;
                                r_i       <= '1;
                            end
                            OP_ADD: begin
                                r_i      <= '1;
                                r_status <= (count_need > (CW+1)'(MAX_EDGES)) ?
                                            ST_FULL : ST_OK;
                            end
                            OP_QUERY: begin
                                r_reached <= NODES'(1) << i_in_item.node_a;
                                r_pending <= NODES'(1) << i_in_item.node_a;
                                r_walks   <= '0;
                                r_found   <= 1'b0;
                                r_i       <= '0;
                                r_status  <= (r_present[i_in_item.node_a] &&
                                              r_present[i_in_item.node_b]) ?
                                             ST_OK : ST_UNKNOWN;
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_i      <= '1;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_i <= '0;
                    if (div_done) begin
                        r_count   <= CW'(count_need);
                        r_present <= r_present | (NODES'(1) << r_a) | (NODES'(1) << r_b);
                    end
                end
                S_QSCAN: begin
                    r_i <= r_i + (NODE_W+1)'(1);
                    if (scan_take) begin
                        r_found <= 1'b1;
                        r_min   <= best_rd;
                        r_u     <= scan_j;
                    end
                end
                S_QPICK: begin
                    if (r_found) begin
                        if (r_walks >= WW'(WALK_LIMIT)) begin
                            r_status <= ST_WALK;
                        end else begin
                            r_walks   <= r_walks + WW'(1);
                            r_pending <= r_pending & ~(NODES'(1) << r_u);
                            r_bu      <= r_min;
                            r_e       <= '0;
                        end
                    end
                end
                S_ERD: begin
                    if (r_e == r_count) begin
                        r_i     <= '0;
                        r_found <= 1'b0;
                    end
                end
                S_ECHK: begin
                    r_v <= edge_rd.to_node;
                    if (edge_rd.from_node != r_u) begin
                        r_e <= r_e + CW'(1);
                    end
                end
                S_EUPD: begin
                    r_e <= r_e + CW'(1);
                    if (upd_take) begin
                        r_reached <= r_reached | (NODES'(1) << r_v);
                        r_pending <= r_pending | (NODES'(1) << r_v);
                        // a self loop changes the product used by later edges
                        if (r_v == r_u) begin
                            r_bu <= mul_p;
                        end
                    end
                end
                S_QEND: begin
                    if (r_reached[r_b]) begin
                        r_ratio <= best_rd;
                    end else begin
                        r_status <= ST_UNREACH;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        o_out_item.status <= r_status;
                        o_out_item.ratio  <= (r_status == ST_OK) ? r_ratio : 32'd0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

@@ tb/rgq_checker.sv @@
// Checker for the ratio graph query engine: predicts each command's result and compares.
`default_nettype none
module rgq_checker
    import rgq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_item,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EDGE_CAP   = 64;
    localparam int WALK_CAP   = 1024;
    localparam logic [31:0] SAT = 32'hFFFF_FFFF;

    t_edge       graph_edges[EDGE_CAP];
    int          graph_edge_cnt;
    logic [31:0] graph_nodes;
    t_out_item   ratio_results_due[$];

    function automatic logic [31:0] scale_q16(logic [31:0] x, logic [31:0] w);
        logic [63:0] p;
        p = ({32'b0, x} * {32'b0, w}) >> 16;
        return (p > {32'b0, SAT}) ? SAT : p[31:0];
    endfunction

    function automatic logic [31:0] inverse_q16(logic [31:0] w);
        logic [63:0] r;
        if (w == 32'd0)
            return SAT;
        r = 64'h1_0000_0000 / {32'b0, w};
        return (r > {32'b0, SAT}) ? SAT : r[31:0];
    endfunction

    // Best-first walk for the smallest product from src to dst.
    function automatic t_out_item walk_ratio(logic [4:0] src, logic [4:0] dst);
        logic [31:0] best[NODES];
        bit          reached[NODES];
        bit          pend[NODES];
        int          walks;
        int          u;
        logic [31:0] p;
        t_out_item   res;
        walks = 0;
        res = '0;
        for (int i = 0; i < NODES; i++) begin
            best[i] = '0;
            reached[i] = 0;
            pend[i] = 0;
        end
        best[src] = ONE_Q16;
        reached[src] = 1;
        pend[src] = 1;
        forever begin
            u = -1;
            for (int i = 0; i < NODES; i++)
                if (pend[i] && (u < 0 || best[i] < best[u]))
                    u = i;
            if (u < 0)
                break;
            if (walks >= WALK_CAP) begin
                res.status = ST_WALK;
                return res;
            end
            walks++;
            pend[u] = 0;
            for (int e = 0; e < graph_edge_cnt; e++) begin
                if (graph_edges[e].from_node != u)
                    continue;
                p = scale_q16(best[u], graph_edges[e].wt);
                if (!reached[graph_edges[e].to_node] || best[graph_edges[e].to_node] > p) begin
                    best[graph_edges[e].to_node] = p;
                    reached[graph_edges[e].to_node] = 1;
                    pend[graph_edges[e].to_node] = 1;
                end
            end
        end
        if (!reached[dst]) begin
            res.status = ST_UNREACH;
            return res;
        end
        res.status = ST_OK;
        res.ratio = best[dst];
        return res;
    endfunction

    function automatic t_out_item apply_command(t_in_item it);
        t_out_item res;
        res = '0;
        case (t_op'(it.operation))
            OP_CLEAR: begin
                graph_edge_cnt = 0;
                graph_nodes = '0;
            end
            OP_ADD: begin
                if (graph_edge_cnt + 2 > EDGE_CAP) begin
                    res.status = ST_FULL;
                end else begin
                    graph_edges[graph_edge_cnt] = '{it.node_a, it.node_b, it.weight};
                    graph_edges[graph_edge_cnt + 1] =
                        '{it.node_b, it.node_a, inverse_q16(it.weight)};
                    graph_edge_cnt += 2;
                    graph_nodes[it.node_a] = 1'b1;
                    graph_nodes[it.node_b] = 1'b1;
                end
            end
            OP_QUERY: begin
                if (!graph_nodes[it.node_a] || !graph_nodes[it.node_b])
                    res.status = ST_UNKNOWN;
                else
                    res = walk_ratio(it.node_a, it.node_b);
            end
            default: ;
        endcase
        return res;
    endfunction

    assign o_pending = ratio_results_due.size();

    initial begin
        graph_edge_cnt = 0;
        graph_nodes = '0;
        o_fail_count = 0;
    end

    always @(posedge i_clk) begin
        t_out_item exp_res;
        t_out_item new_res;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                new_res = apply_command(i_in_item);
                ratio_results_due = {ratio_results_due, new_res};
            end
            if (i_out_valid && !i_out_stall) begin
                if (ratio_results_due.size() == 0) begin
                    $error("result with nothing expected: status %0d ratio %h",
                           i_out_item.status, i_out_item.ratio);
                    o_fail_count++;
                end else begin
                    exp_res = ratio_results_due.pop_front();
                    if (i_out_item.status !== exp_res.status) begin
                        $error("status: expected %0d actual %0d",
                               exp_res.status, i_out_item.status);
                        o_fail_count++;
                    end
                    if (i_out_item.ratio !== exp_res.ratio) begin
                        $error("ratio: expected %h actual %h",
                               exp_res.ratio, i_out_item.ratio);
                        o_fail_count++;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench top: stimulus, idling and verdict for the ratio graph query engine.
`default_nettype none
module tb_top;
    import rgq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 200_000_000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;
    int        fail_count;
    int        pending;
    bit        quiet = 0;
    int        stall_left = 0;
    longint    cycles = 0;
    int        adds_since_clear = 0;

    always #1 i_clk = ~i_clk;

    ratio_graph_query_engine_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    rgq_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_item  (o_out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Receiver stalls in bursts.
    always @(posedge i_clk) begin
        if (quiet) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(0, 16);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_cmd(t_op op, logic [4:0] a, logic [4:0] b, logic [31:0] w);
        t_in_item it;
        it = '{op, a, b, w};
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (op == OP_ADD)
            adds_since_clear++;
        if (op == OP_CLEAR)
            adds_since_clear = 0;
    endtask

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return $urandom();
            1:       return 32'd0;
            2:       return 32'd1;
            3:       return 32'hFFFF_FFFF;
            default: return 32'd1 << $urandom_range(8, 24);
        endcase
    endfunction

    function automatic logic [4:0] pick_node();
        return ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, 5));
    endfunction

    initial begin
        int r;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: unknown nodes, op three, extremes, saturation, self query.
        send_cmd(OP_QUERY, 5'd0, 5'd31, 32'd0);
        send_cmd(OP_NOP, 5'd31, 5'd31, 32'hFFFF_FFFF);
        send_cmd(OP_ADD, 5'd0, 5'd1, 32'h0002_0000);
        send_cmd(OP_ADD, 5'd1, 5'd2, 32'd0);
        send_cmd(OP_ADD, 5'd3, 5'd31, 32'd1);
        send_cmd(OP_ADD, 5'd4, 5'd5, 32'hFFFF_FFFF);
        send_cmd(OP_QUERY, 5'd0, 5'd2, 32'd0);
        send_cmd(OP_QUERY, 5'd2, 5'd0, 32'd0);
        send_cmd(OP_QUERY, 5'd31, 5'd3, 32'd0);
        send_cmd(OP_QUERY, 5'd0, 5'd4, 32'd0);
        send_cmd(OP_QUERY, 5'd5, 5'd5, 32'd0);
        send_cmd(OP_QUERY, 5'd0, 5'd9, 32'd0);
        send_cmd(OP_CLEAR, 5'd0, 5'd0, 32'd0);
        send_cmd(OP_QUERY, 5'd0, 5'd1, 32'd0);
        // Inconsistent pair that truncation keeps lowering until the self ratio reaches zero.
        send_cmd(OP_ADD, 5'd6, 5'd7, 32'd3);
        send_cmd(OP_QUERY, 5'd6, 5'd6, 32'd0);
        send_cmd(OP_CLEAR, 5'd0, 5'd0, 32'd0);
        // Fill the edge table with a chain, then overflow it.
        for (int i = 0; i < 32; i++)
            send_cmd(OP_ADD, 5'(i), 5'((i + 1) % 32), 32'h0001_0000);
        send_cmd(OP_ADD, 5'd1, 5'd2, 32'h0002_0000);
        send_cmd(OP_QUERY, 5'd0, 5'd16, 32'd0);
        send_cmd(OP_CLEAR, 5'd0, 5'd0, 32'd0);

        for (int n = 0; n < 90; n++) begin
            if (n >= 75)
                quiet = 1;
            r = $urandom_range(0, 99);
            if (adds_since_clear >= 8 || r < 7)
                send_cmd(OP_CLEAR, pick_node(), pick_node(), $urandom());
            else if (r < 52)
                send_cmd(OP_ADD, pick_node(), pick_node(), pick_weight());
            else if (r < 94)
                send_cmd(OP_QUERY, pick_node(), pick_node(), $urandom());
            else
                send_cmd(OP_NOP, pick_node(), pick_node(), $urandom());
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
`default_nettype wire

@@ sim.f @@
hw/rtl/rgq_pkg.sv
hw/rtl/rgq_recip.sv
hw/rtl/rgq_mulsat.sv
hw/rtl/ratio_graph_query_engine_core.sv
tb/rgq_checker.sv
tb/tb_top.sv
